FILE: rtl/pcc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the palette cycler.
package pcc_pkg;

   localparam int MAX_RANGES  = 4;
   localparam int PAL_ENTRIES = 256;
   localparam int PAL_AW      = $clog2(PAL_ENTRIES);
   localparam int RANGE_AW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int RCNT_W      = $clog2(MAX_RANGES + 1);

   localparam int COLOR_W     = 8;
   localparam int RGB_W       = 3 * COLOR_W;
   localparam int FRAME_W     = 32;
   localparam int INDEX_W     = 8;
   localparam int FIRST_W     = 8;
   localparam int COUNT_W     = 9;
   localparam int PERIOD_W    = 16;
   localparam int WORD_W      = FIRST_W + COUNT_W + PERIOD_W;
   localparam int TOTAL_W     = 11;
   localparam int DIV_W       = 2;
   localparam int LEN_W       = PAL_AW + 1;

   localparam int CSR_IDX_W   = 3;
   localparam int RCOUNT_W    = 3;

   localparam int BIG_TOTAL   = 16;
   localparam int DIV_SLOW    = 3;

   // request kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_START = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RCOUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE0 = 3'd2;

   typedef struct packed {
      logic capture;
      logic pal_write;
      logic pal_read;
      logic start_stamps;
      logic tick_eval;
      logic range_eval;
      logic rot_read_last;
      logic rot_cap_last;
      logic rot_read_k;
      logic rot_write_k;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic tick_run;
      logic range_end;
      logic range_rotate;
      logic rot_last;
      logic rsp_free;
   } sts_type;

endpackage

FILE: rtl/palette_color_cycler_unit.sv
// Palette color cycler top level: one item at a time through controller and datapath.
// Write/read/start: capture, palette access or stamping, output register load.
// Tick: capture, divider step, and when let through a check of each range in use and an
// end check (a rotating range reads its last entry, then reads and writes each in turn).
// A new item is taken once the previous one is in the output register.
// Reset (synchronous): registers, stamps, divider and palette valid bits clear at once;
// the palette reads as zero until written, with no clearing pass.
module palette_color_cycler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [pcc_pkg::FRAME_W-1:0]     req_frame_count,
   input  logic [pcc_pkg::INDEX_W-1:0]     req_entry_index,
   input  logic [pcc_pkg::COLOR_W-1:0]     req_red_in,
   input  logic [pcc_pkg::COLOR_W-1:0]     req_green_in,
   input  logic [pcc_pkg::COLOR_W-1:0]     req_blue_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pcc_pkg::COLOR_W-1:0]     rsp_red_out,
   output logic [pcc_pkg::COLOR_W-1:0]     rsp_green_out,
   output logic [pcc_pkg::COLOR_W-1:0]     rsp_blue_out,
   output logic                            rsp_palette_changed,
   output logic [pcc_pkg::FIRST_W-1:0]     rsp_refresh_first,
   output logic [pcc_pkg::TOTAL_W-1:0]     rsp_refresh_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcc_pkg::WORD_W-1:0]      csr_data
);
   import pcc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // register writes are accepted whenever reset is not held
   assign csr_ready = !reset;

   pcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcc_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_type            (req_type),
      .req_frame_count     (req_frame_count),
      .req_entry_index     (req_entry_index),
      .req_red_in          (req_red_in),
      .req_green_in        (req_green_in),
      .req_blue_in         (req_blue_in),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_red_out         (rsp_red_out),
      .rsp_green_out       (rsp_green_out),
      .rsp_blue_out        (rsp_blue_out),
      .rsp_palette_changed (rsp_palette_changed),
      .rsp_refresh_first   (rsp_refresh_first),
      .rsp_refresh_count   (rsp_refresh_count)
   );

endmodule

FILE: rtl/pcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pcc_ctrl.sv
// Controller state machine: sequences palette access, stamping, ticks and range rotation.
module pcc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_type,
   output logic             req_ready,
   input  pcc_pkg::sts_type sts,
   output pcc_pkg::cmd_type cmd
);
   import pcc_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_WRITE    = 4'd1;
   localparam logic [3:0] S_READ     = 4'd2;
   localparam logic [3:0] S_START    = 4'd3;
   localparam logic [3:0] S_TICK     = 4'd4;
   localparam logic [3:0] S_RANGE    = 4'd5;
   localparam logic [3:0] S_ROT_LAST = 4'd6;
   localparam logic [3:0] S_ROT_CAP  = 4'd7;
   localparam logic [3:0] S_ROT_RD   = 4'd8;
   localparam logic [3:0] S_ROT_WR   = 4'd9;
   localparam logic [3:0] S_FINISH   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // take no transfer while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_WRITE: state_in = S_WRITE;
                  REQ_READ:  state_in = S_READ;
                  REQ_START: state_in = S_START;
                  default:   state_in = S_TICK;
               endcase
            end
         end
         S_WRITE: begin
            cmd.pal_write = 1'b1;
            state_in      = S_FINISH;
         end
         S_READ: begin
            cmd.pal_read = 1'b1;
            state_in     = S_FINISH;
         end
         S_START: begin
            cmd.start_stamps = 1'b1;
            state_in         = S_FINISH;
         end
         S_TICK: begin
            cmd.tick_eval = 1'b1;
            state_in      = sts.tick_run ? S_RANGE : S_FINISH;
         end
         S_RANGE: begin
            cmd.range_eval = 1'b1;
            if (sts.range_end) begin
               state_in = S_FINISH;
            end else if (sts.range_rotate) begin
               state_in = S_ROT_LAST;
            end
         end
         S_ROT_LAST: begin
            cmd.rot_read_last = 1'b1;
            state_in          = S_ROT_CAP;
         end
         S_ROT_CAP: begin
            cmd.rot_cap_last = 1'b1;
            state_in         = S_ROT_RD;
         end
         S_ROT_RD: begin
            cmd.rot_read_k = 1'b1;
            state_in       = S_ROT_WR;
         end
         S_ROT_WR: begin
            cmd.rot_write_k = 1'b1;
            state_in        = sts.rot_last ? S_RANGE : S_ROT_RD;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/pcc_datapath.sv
// Datapath: registers, range stamps, divider, palette RAM with valid bits and result register.
module pcc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  pcc_pkg::cmd_type                cmd,
   output pcc_pkg::sts_type                sts,
   input  logic [1:0]                      req_type,
   input  logic [pcc_pkg::FRAME_W-1:0]     req_frame_count,
   input  logic [pcc_pkg::INDEX_W-1:0]     req_entry_index,
   input  logic [pcc_pkg::COLOR_W-1:0]     req_red_in,
   input  logic [pcc_pkg::COLOR_W-1:0]     req_green_in,
   input  logic [pcc_pkg::COLOR_W-1:0]     req_blue_in,
   input  logic                            csr_valid,
   input  logic [pcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcc_pkg::WORD_W-1:0]      csr_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [pcc_pkg::COLOR_W-1:0]     rsp_red_out,
   output logic [pcc_pkg::COLOR_W-1:0]     rsp_green_out,
   output logic [pcc_pkg::COLOR_W-1:0]     rsp_blue_out,
   output logic                            rsp_palette_changed,
   output logic [pcc_pkg::FIRST_W-1:0]     rsp_refresh_first,
   output logic [pcc_pkg::TOTAL_W-1:0]     rsp_refresh_count
);
   import pcc_pkg::*;

   // configuration
   logic                enable_ff;
   logic [RCOUNT_W-1:0] rcount_ff;
   logic [WORD_W-1:0]   range_word_ff [MAX_RANGES];

   // item registers
   logic [1:0]          type_ff;
   logic [FRAME_W-1:0]  frame_ff;
   logic [PAL_AW-1:0]   index_ff;
   logic [RGB_W-1:0]    rgb_ff;

   // cycling state
   logic [FRAME_W-1:0]  stamp_ff [MAX_RANGES];
   logic [DIV_W-1:0]    div_ff;
   logic [RCNT_W-1:0]   r_ff;
   logic [LEN_W-1:0]    k_ff;
   logic [RGB_W-1:0]    carry_ff;
   logic                changed_ff;

   // palette valid bits and read mask
   logic                pal_valid_ff [PAL_ENTRIES];
   logic                rd_valid_ff;

   // result register
   logic                rsp_valid_ff;
   logic [RGB_W-1:0]    rsp_rgb_ff;
   logic                rsp_changed_ff;
   logic [FIRST_W-1:0]  rsp_first_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;

   logic [RCNT_W-1:0]   used;
   logic [TOTAL_W-1:0]  total;
   logic [DIV_W-1:0]    div_next;
   logic [DIV_W-1:0]    threshold;
   logic [RANGE_AW-1:0] rsel;
   logic [FIRST_W-1:0]  cur_first;
   logic [COUNT_W-1:0]  cur_count;
   logic [PERIOD_W-1:0] cur_period;
   logic [LEN_W-1:0]    cur_len;
   logic [FRAME_W-1:0]  due;
   logic                fire;
   logic [PAL_AW-1:0]   pos_k;
   logic [PAL_AW-1:0]   pos_last;
   logic [CSR_IDX_W-1:0] csr_widx;

   logic                ram_we;
   logic [PAL_AW-1:0]   ram_waddr;
   logic [RGB_W-1:0]    ram_wdata;
   logic                ram_re;
   logic [PAL_AW-1:0]   ram_raddr;
   logic [RGB_W-1:0]    ram_q;
   logic [RGB_W-1:0]    rdata;

   // ranges in use and their total colour count, from the live registers
   always_comb begin
      if (RCNT_W'(rcount_ff) > RCNT_W'(MAX_RANGES)) begin
         used = RCNT_W'(MAX_RANGES);
      end else begin
         used = RCNT_W'(rcount_ff);
      end
      total = '0;
      for (int i = 0; i < MAX_RANGES; i++) begin
         if (RCNT_W'(i) < used) begin
            total = total + TOTAL_W'(range_word_ff[i][FIRST_W +: COUNT_W]);
         end
      end
   end

   assign threshold = (total > TOTAL_W'(BIG_TOTAL)) ? DIV_W'(DIV_SLOW) : '0;
   assign div_next  = div_ff + 1'b1;

   assign rsel       = r_ff[RANGE_AW-1:0];
   assign cur_first  = range_word_ff[rsel][0 +: FIRST_W];
   assign cur_count  = range_word_ff[rsel][FIRST_W +: COUNT_W];
   assign cur_period = range_word_ff[rsel][FIRST_W + COUNT_W +: PERIOD_W];
   assign cur_len    = (cur_count > COUNT_W'(PAL_ENTRIES)) ? LEN_W'(PAL_ENTRIES)
                                                           : LEN_W'(cur_count);
   assign due        = stamp_ff[rsel] + FRAME_W'(cur_period);
   assign fire       = (frame_ff >= due);
   assign pos_k      = PAL_AW'(cur_first) + k_ff[PAL_AW-1:0];
   assign pos_last   = PAL_AW'(cur_first) + PAL_AW'(cur_len - 1'b1);

   assign sts.tick_run     = enable_ff && (div_next >= threshold);
   assign sts.range_end    = (r_ff == used);
   assign sts.range_rotate = fire && (cur_len >= LEN_W'(2));
   assign sts.rot_last     = (k_ff == cur_len - 1'b1);
   assign sts.rsp_free     = !rsp_valid_ff || rsp_ready;

   // palette port selection
   assign ram_we    = cmd.pal_write || cmd.rot_write_k;
   assign ram_waddr = cmd.pal_write ? index_ff : pos_k;
   assign ram_wdata = cmd.pal_write ? rgb_ff : carry_ff;
   assign ram_re    = cmd.pal_read || cmd.rot_read_last || cmd.rot_read_k;
   always_comb begin
      if (cmd.pal_read) begin
         ram_raddr = index_ff;
      end else if (cmd.rot_read_last) begin
         ram_raddr = pos_last;
      end else begin
         ram_raddr = pos_k;
      end
   end

   // an entry never written since reset reads as zero
   assign rdata = rd_valid_ff ? ram_q : '0;

   pcc_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PAL_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign csr_widx = csr_index - CSR_RANGE0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         rcount_ff    <= '0;
         div_ff       <= '0;
         r_ff         <= '0;
         k_ff         <= '0;
         changed_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_RANGES; i++) begin
            range_word_ff[i] <= '0;
            stamp_ff[i]      <= '0;
         end
         for (int i = 0; i < PAL_ENTRIES; i++) begin
            pal_valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_ENABLE) begin
               enable_ff <= csr_data[0];
            end else if (csr_index == CSR_RCOUNT) begin
               rcount_ff <= csr_data[RCOUNT_W-1:0];
            end else if (csr_index >= CSR_RANGE0 &&
                         32'(csr_widx) < MAX_RANGES) begin
               range_word_ff[csr_widx[RANGE_AW-1:0]] <= csr_data;
            end
         end

         if (cmd.capture) begin
            changed_ff <= 1'b0;
         end

         if (cmd.start_stamps) begin
            for (int i = 0; i < MAX_RANGES; i++) begin
               stamp_ff[i] <= frame_ff;
            end
         end

         if (cmd.tick_eval) begin
            r_ff <= '0;
            if (enable_ff) begin
               div_ff <= sts.tick_run ? '0 : div_next;
            end
         end

         if (cmd.range_eval && !sts.range_end) begin
            if (fire) begin
               stamp_ff[rsel] <= frame_ff;
               changed_ff     <= 1'b1;
            end
            if (sts.range_rotate) begin
               k_ff <= '0;
            end else begin
               r_ff <= r_ff + 1'b1;
            end
         end

         if (cmd.rot_write_k) begin
            k_ff <= k_ff + 1'b1;
            if (sts.rot_last) begin
               r_ff <= r_ff + 1'b1;
            end
         end

         if (ram_we) begin
            pal_valid_ff[ram_waddr] <= 1'b1;
         end
         if (ram_re) begin
            rd_valid_ff <= pal_valid_ff[ram_raddr];
         end

         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         frame_ff <= req_frame_count;
         index_ff <= PAL_AW'(req_entry_index);
         rgb_ff   <= {req_red_in, req_green_in, req_blue_in};
      end
      if (cmd.rot_cap_last || cmd.rot_write_k) begin
         carry_ff <= rdata;
      end
      if (cmd.rsp_load) begin
         rsp_rgb_ff     <= (type_ff == REQ_READ) ? rdata : '0;
         rsp_changed_ff <= (type_ff == REQ_TICK) && changed_ff;
         rsp_total_ff   <= (type_ff == REQ_TICK) ? total : '0;
         if (type_ff == REQ_TICK && used != '0) begin
            rsp_first_ff <= range_word_ff[0][0 +: FIRST_W];
         end else begin
            rsp_first_ff <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_red_out         = rsp_rgb_ff[2*COLOR_W +: COLOR_W];
   assign rsp_green_out       = rsp_rgb_ff[COLOR_W +: COLOR_W];
   assign rsp_blue_out        = rsp_rgb_ff[0 +: COLOR_W];
   assign rsp_palette_changed = rsp_changed_ff;
   assign rsp_refresh_first   = rsp_first_ff;
   assign rsp_refresh_count   = rsp_total_ff;

endmodule
